// File: rtl/xavu_pkg.sv
// Package: shared types, codes and character constants of the attribute value unescaper.
package xavu_pkg;

    // Parser modes
    localparam logic [2:0] MODE_WAIT   = 3'd0;
    localparam logic [2:0] MODE_VALUE  = 3'd1;
    localparam logic [2:0] MODE_RSTART = 3'd2;
    localparam logic [2:0] MODE_NAME   = 3'd3;
    localparam logic [2:0] MODE_HASH   = 3'd4;
    localparam logic [2:0] MODE_DEC    = 3'd5;
    localparam logic [2:0] MODE_HEX    = 3'd6;

    // Result kinds
    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_REF   = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_NOVAL = 2'd3;

    // Characters
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] HEX_LOWER_BIAS = 8'd87;
    localparam logic [7:0] HEX_UPPER_BIAS = 8'd55;

    // Packed reference names, last byte in the low position
    localparam logic [31:0] NAME_GT   = 32'h0000_6774;
    localparam logic [31:0] NAME_LT   = 32'h0000_6C74;
    localparam logic [31:0] NAME_AMP  = 32'h0061_6D70;
    localparam logic [31:0] NAME_APOS = 32'h6170_6F73;
    localparam logic [31:0] NAME_QUOT = 32'h7175_6F74;

    localparam logic [2:0] NAME_KEEP_MAX = 3'd4;
    localparam logic [2:0] NAME_LEN_SAT  = 3'd5;

    typedef struct packed {
        logic [2:0]  mode;
        logic        quote_is_double;
        logic [31:0] name_chars;
        logic [2:0]  name_length;
        logic [31:0] accumulator;
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] code;
        logic        last;
    } result_t;

endpackage

// File: rtl/xavu_text_if.sv
// Interface: byte request channel into the unescaper.
interface xavu_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// File: rtl/xavu_result_if.sv
// Interface: result request channel out of the unescaper.
interface xavu_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] code;
    logic        last;

    modport source (output valid, output kind, output code, output last, input ready);
    modport sink   (input valid, input kind, input code, input last, output ready);
endinterface

// File: rtl/xml_attr_value_unescaper.sv
// Top level: XML attribute value unescaper, one byte per cycle unless stalled.
//
// Usage
//   text   : byte requests (data_byte, end_of_stream). The first byte of a
//            value must be an apostrophe or a double quote; otherwise a
//            "no value present" result is given and the next byte is tried.
//   result : result requests (kind, code, last). kind is plain byte,
//            reference code, value ended or no value present; last marks
//            the final result caused by one input byte.
//   Path: a byte accepted into the input register is decoded there, and its
//   results are registered in the result stage before they are offered.
//   Throughput: one byte per cycle while each byte causes at most one
//   result and result.ready stays high. End of stream adds "value ended"
//   after a plain byte, a closed reference or a pending reference code,
//   so such a byte has two results; they may hold off the next byte.
//   Reset: clears the parser to "waiting for opening quote" and empties
//   both register stages.
//   Stall: when the receiver holds ready low, results wait in the result
//   stage, the decoded byte waits in the input register, and text.ready drops
//   while that byte's results do not fit; no request is lost or repeated.
module xml_attr_value_unescaper
(
    input  logic          clk,
    input  logic          rst_n,
    xavu_text_if.sink     text,
    xavu_result_if.source result
);

    // Input register
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_eos_reg;

    // Parser state
    xavu_pkg::state_t       state_reg;
    xavu_pkg::state_t       state_next;

    logic [1:0]             res_count;
    xavu_pkg::result_t      res0;
    xavu_pkg::result_t      res1;
    logic [1:0]             free_slots;
    logic                   fire;
    logic [1:0]             push_count;

    xavu_step u_step
    (
        .state         (state_reg),
        .data_byte     (in_byte_reg),
        .end_of_stream (in_eos_reg),
        .state_next    (state_next),
        .res_count     (res_count),
        .res0          (res0),
        .res1          (res1)
    );

    // Advance the held byte only when its results all fit in the result stage
    assign fire       = in_valid_reg && (res_count <= free_slots);
    assign push_count = fire ? res_count : 2'd0;
    assign text.ready = !in_valid_reg || fire;

    xavu_outq u_outq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .free_slots (free_slots),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '{mode: xavu_pkg::MODE_WAIT, quote_is_double: 1'b0,
                              name_chars: 32'd0, name_length: 3'd0,
                              accumulator: 32'd0};
        end
        else
        begin
            if (text.ready)
                in_valid_reg <= text.valid;
            if (fire)
                state_reg <= state_next;
        end
    end

    // Hold the payload while the byte waits
    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            in_byte_reg <= text.data_byte;
            in_eos_reg  <= text.end_of_stream;
        end
    end

endmodule

// File: rtl/xavu_step.sv
// Step logic: next parser state and up to two results for one byte.
module xavu_step
(
    input  xavu_pkg::state_t  state,
    input  logic [7:0]        data_byte,
    input  logic              end_of_stream,
    output xavu_pkg::state_t  state_next,
    output logic [1:0]        res_count,
    output xavu_pkg::result_t res0,
    output xavu_pkg::result_t res1
);

    function automatic logic [31:0] lookup_name(input logic [31:0] chars,
                                                input logic [2:0] len);
        logic [31:0] ret;
        ret = 32'd0;
        if (len == 3'd2 && chars == xavu_pkg::NAME_GT)
            ret = {24'd0, xavu_pkg::CH_GT};
        else if (len == 3'd2 && chars == xavu_pkg::NAME_LT)
            ret = {24'd0, xavu_pkg::CH_LT};
        else if (len == 3'd3 && chars == xavu_pkg::NAME_AMP)
            ret = {24'd0, xavu_pkg::CH_AMP};
        else if (len == 3'd4 && chars == xavu_pkg::NAME_APOS)
            ret = {24'd0, xavu_pkg::CH_APOS};
        else if (len == 3'd4 && chars == xavu_pkg::NAME_QUOT)
            ret = {24'd0, xavu_pkg::CH_QUOT};
        return ret;
    endfunction

    logic [7:0]  quote;
    logic        is_semi;
    logic        is_dig;
    logic        is_lhex;
    logic        is_uhex;
    logic        name_path;
    logic        dec_path;
    logic [7:0]  dig_val;
    logic [7:0]  lhex_val;
    logic [7:0]  uhex_val;
    logic [31:0] acc_dec;
    logic        step_emit;
    logic [1:0]  step_kind;
    logic [31:0] step_code;
    xavu_pkg::state_t s;

    assign quote    = state.quote_is_double ? xavu_pkg::CH_QUOT : xavu_pkg::CH_APOS;
    assign is_semi  = (data_byte == xavu_pkg::CH_SEMI);
    assign is_dig   = (data_byte >= xavu_pkg::CH_ZERO) && (data_byte <= xavu_pkg::CH_NINE);
    assign is_lhex  = (data_byte >= xavu_pkg::CH_LA) && (data_byte <= xavu_pkg::CH_LF);
    assign is_uhex  = (data_byte >= xavu_pkg::CH_UA) && (data_byte <= xavu_pkg::CH_UF);
    assign dig_val  = data_byte - xavu_pkg::CH_ZERO;
    assign lhex_val = data_byte - xavu_pkg::HEX_LOWER_BIAS;
    assign uhex_val = data_byte - xavu_pkg::HEX_UPPER_BIAS;
    assign acc_dec  = {state.accumulator[28:0], 3'b000} + {state.accumulator[30:0], 1'b0}
                      + {28'd0, dig_val[3:0]};

    // A name byte arrives in RSTART (unless it opens a number) or in NAME
    assign name_path = (state.mode == xavu_pkg::MODE_NAME)
                       || (state.mode == xavu_pkg::MODE_RSTART
                           && data_byte != xavu_pkg::CH_HASH);
    assign dec_path  = (state.mode == xavu_pkg::MODE_DEC)
                       || (state.mode == xavu_pkg::MODE_HASH && data_byte != xavu_pkg::CH_X);

    always_comb
    begin
        s         = state;
        step_emit = 1'b0;
        step_kind = xavu_pkg::KIND_PLAIN;
        step_code = 32'd0;

        priority if (state.mode == xavu_pkg::MODE_VALUE)
        begin
            if (data_byte == quote)
            begin
                step_emit = 1'b1;
                step_kind = xavu_pkg::KIND_END;
                s.mode    = xavu_pkg::MODE_WAIT;
            end
            else if (data_byte == xavu_pkg::CH_AMP)
            begin
                s.accumulator = 32'd0;
                s.name_chars  = 32'd0;
                s.name_length = 3'd0;
                s.mode        = xavu_pkg::MODE_RSTART;
            end
            else
            begin
                step_emit = 1'b1;
                step_kind = xavu_pkg::KIND_PLAIN;
                step_code = {24'd0, data_byte};
            end
        end
        else if (state.mode == xavu_pkg::MODE_RSTART && data_byte == xavu_pkg::CH_HASH)
        begin
            s.mode = xavu_pkg::MODE_HASH;
        end
        else if (name_path)
        begin
            if (is_semi)
            begin
                step_emit = 1'b1;
                step_kind = xavu_pkg::KIND_REF;
                step_code = lookup_name(state.name_chars, state.name_length);
                s.mode    = xavu_pkg::MODE_VALUE;
            end
            else
            begin
                s.mode = xavu_pkg::MODE_NAME;
                if (state.name_length < xavu_pkg::NAME_KEEP_MAX)
                    s.name_chars = {state.name_chars[23:0], data_byte};
                if (state.name_length < xavu_pkg::NAME_LEN_SAT)
                    s.name_length = state.name_length + 3'd1;
            end
        end
        else if (state.mode == xavu_pkg::MODE_HASH && data_byte == xavu_pkg::CH_X)
        begin
            // only lowercase x selects hex here
            s.mode = xavu_pkg::MODE_HEX;
        end
        else if (dec_path)
        begin
            if (is_semi)
            begin
                step_emit = 1'b1;
                step_kind = xavu_pkg::KIND_REF;
                step_code = state.accumulator;
                s.mode    = xavu_pkg::MODE_VALUE;
            end
            else
            begin
                s.mode = xavu_pkg::MODE_DEC;
                if (is_dig)
                    s.accumulator = acc_dec;
            end
        end
        else if (state.mode == xavu_pkg::MODE_HEX)
        begin
            if (is_semi)
            begin
                step_emit = 1'b1;
                step_kind = xavu_pkg::KIND_REF;
                step_code = state.accumulator;
                s.mode    = xavu_pkg::MODE_VALUE;
            end
            else if (is_dig)
                s.accumulator = {state.accumulator[27:0], dig_val[3:0]};
            else if (is_lhex)
                s.accumulator = {state.accumulator[27:0], lhex_val[3:0]};
            else if (is_uhex)
                s.accumulator = {state.accumulator[27:0], uhex_val[3:0]};
        end
        else
        begin
            // waiting for the opening quote; unused codes land here too
            if (data_byte == xavu_pkg::CH_APOS || data_byte == xavu_pkg::CH_QUOT)
            begin
                s.quote_is_double = (data_byte == xavu_pkg::CH_QUOT);
                s.mode            = xavu_pkg::MODE_VALUE;
            end
            else
            begin
                step_emit = 1'b1;
                step_kind = xavu_pkg::KIND_NOVAL;
                s.mode    = xavu_pkg::MODE_WAIT;
            end
        end
    end

    // Append the end-of-stream flush and mark the final result
    always_comb
    begin
        state_next = s;
        res_count  = 2'd0;
        res0       = '{kind: step_kind, code: step_code, last: 1'b0};
        res1       = '{kind: xavu_pkg::KIND_END, code: 32'd0, last: 1'b1};

        if (step_emit)
            res_count = 2'd1;

        if (end_of_stream && s.mode != xavu_pkg::MODE_WAIT)
        begin
            state_next.mode = xavu_pkg::MODE_WAIT;
            if (s.mode != xavu_pkg::MODE_VALUE)
            begin
                // pending reference: no step result was given in this case
                res0      = '{kind: xavu_pkg::KIND_REF, code: s.accumulator, last: 1'b0};
                res_count = 2'd2;
            end
            else if (step_emit)
                res_count = 2'd2;
            else
            begin
                res0      = '{kind: xavu_pkg::KIND_END, code: 32'd0, last: 1'b0};
                res_count = 2'd1;
            end
        end

        if (res_count == 2'd1)
            res0.last = 1'b1;
    end

endmodule

// File: rtl/xavu_outq.sv
// Result queue: two-slot register stage; takes up to two results, gives one a cycle if ready.
module xavu_outq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_count,
    input  xavu_pkg::result_t push0,
    input  xavu_pkg::result_t push1,
    output logic [1:0]        free_slots,
    xavu_result_if.source     result
);

    xavu_pkg::result_t slot0_reg, slot0_next;
    xavu_pkg::result_t slot1_reg, slot1_next;
    logic [1:0]        count_reg, count_next;
    logic              pop;
    xavu_pkg::result_t base1;
    logic [1:0]        base_count;

    assign pop          = result.valid && result.ready;
    assign result.valid = (count_reg != 2'd0);
    assign result.kind  = slot0_reg.kind;
    assign result.code  = slot0_reg.code;
    assign result.last  = slot0_reg.last;
    assign free_slots   = 2'd2 - count_reg + {1'b0, pop};

    always_comb
    begin
        base_count = count_reg - {1'b0, pop};
        slot0_next = pop ? slot1_reg : slot0_reg;
        base1      = slot1_reg;
        slot1_next = base1;
        unique case (base_count)
            2'd0:
            begin
                if (push_count != 2'd0)
                    slot0_next = push0;
                slot1_next = push1;
            end
            2'd1:
            begin
                if (push_count != 2'd0)
                    slot1_next = push0;
            end
            default:
            begin
                slot1_next = base1;
            end
        endcase
        count_next = base_count + push_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule
